// ===== rtl/core/tfid_pkg.sv =====
`default_nettype none

package tfid_pkg;

  localparam int unsigned BUCKETS     = 512;
  localparam int unsigned CHANNELS    = 68;
  localparam int unsigned CHIPS       = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] FTYPE_PARTIAL = 16'd1;
  localparam logic [15:0] FTYPE_FULL    = 16'd2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_PARTIAL = 3'b010,
    MODE_FULL    = 3'b100
  } mode_e;

  // One decoded word: one result, or two for a channel pair.
  typedef struct packed {
    logic        two;
    logic [1:0]  chip;
    logic [6:0]  channel;
    logic [8:0]  bucket;
    logic [11:0] sample0;
    logic [11:0] sample1;
    logic        eof;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/tpc_frame_item_decoder.sv =====
// Each data word's job passes the job queue, then the output register, to reach the port.
// Throughput: one input transfer per cycle while the 2-entry job queue has room; the
// result port then sets the pace: one result per partial-frame word, two per full word.
// Reset (rst_ni, async, active low): idle, no frame active, counters and queue cleared.
`default_nettype none

module tpc_frame_item_decoder
  import tfid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [15:0] frame_type_i,
  input  wire logic [17:0] item_count_i,
  input  wire logic [31:0] data_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       chip_o,
  output logic [6:0]       channel_o,
  output logic [8:0]       bucket_o,
  output logic [11:0]      sample_o,
  output logic             bad_channel_o,
  output logic             last_of_item_o,
  output logic             end_of_frame_o
);

  logic push, full, q_valid, q_ready;
  job_t push_job, q_job;

  assign in_ready_o = !full;

  tfid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_valid_i && in_ready_o),
    .func_i       (func_i),
    .frame_type_i (frame_type_i),
    .item_count_i (item_count_i),
    .data_word_i  (data_word_i),
    .push_o       (push),
    .job_o        (push_job)
  );

  tfid_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (full),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_job_o   (q_job)
  );

  tfid_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_ready_o    (q_ready),
    .job_i          (q_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chip_o         (chip_o),
    .channel_o      (channel_o),
    .bucket_o       (bucket_o),
    .sample_o       (sample_o),
    .bad_channel_o  (bad_channel_o),
    .last_of_item_o (last_of_item_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tfid_front.sv =====
`default_nettype none

module tfid_front
  import tfid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_accept_i,
  input  wire logic        func_i,
  input  wire logic [15:0] frame_type_i,
  input  wire logic [17:0] item_count_i,
  input  wire logic [31:0] data_word_i,
  output logic             push_o,
  output job_t             job_o
);

  mode_e       mode_q, mode_d;
  logic [17:0] items_left_q, items_left_d;
  logic [1:0]  chip_q, chip_d;
  logic [5:0]  pair_q, pair_d;
  logic [8:0]  bucket_q, bucket_d;

  logic [6:0]  ch0;
  logic        chip_wrap, pair_wrap, bucket_wrap;

  assign ch0         = {pair_q, 1'b0};
  assign chip_wrap   = ({1'b0, chip_q} + 3'd1) >= 3'(CHIPS);
  assign pair_wrap   = ({1'b0, ch0} + 8'd2) >= 8'(CHANNELS);
  assign bucket_wrap = ({1'b0, bucket_q} + 10'd1) >= 10'(BUCKETS);

  always_comb begin
    mode_d       = mode_q;
    items_left_d = items_left_q;
    chip_d       = chip_q;
    pair_d       = pair_q;
    bucket_d     = bucket_q;
    push_o       = 1'b0;
    job_o        = '0;
    if (in_accept_i) begin
      if (func_i == FUNC_START) begin
        chip_d       = '0;
        pair_d       = '0;
        bucket_d     = '0;
        items_left_d = '0;
        mode_d       = MODE_IDLE;
        if (frame_type_i == FTYPE_PARTIAL) begin
          items_left_d = item_count_i;
          if (item_count_i != '0) begin
            mode_d = MODE_PARTIAL;
          end
        end else if (frame_type_i == FTYPE_FULL) begin
          mode_d = MODE_FULL;
        end
      end else begin
        case (mode_q)
          MODE_PARTIAL: begin
            push_o        = 1'b1;
            job_o.two     = 1'b0;
            job_o.chip    = data_word_i[7:6];
            job_o.channel = {data_word_i[5:0], data_word_i[15]};
            job_o.bucket  = {data_word_i[14:8], data_word_i[23:22]};
            job_o.sample0 = {data_word_i[19:16], data_word_i[31:24]};
            job_o.eof     = (items_left_q == 18'd1);
            items_left_d  = items_left_q - 18'd1;
            if (items_left_q == 18'd1) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_FULL: begin
            push_o        = 1'b1;
            job_o.two     = 1'b1;
            job_o.chip    = chip_q;
            job_o.channel = ch0;
            job_o.bucket  = bucket_q;
            job_o.sample0 = {data_word_i[3:0], data_word_i[15:8]};
            job_o.sample1 = {data_word_i[19:16], data_word_i[31:24]};
            job_o.eof     = chip_wrap && pair_wrap && bucket_wrap;
            if (chip_wrap) begin
              chip_d = '0;
              if (pair_wrap) begin
                pair_d = '0;
                if (bucket_wrap) begin
                  bucket_d = '0;
                  mode_d   = MODE_IDLE;
                end else begin
                  bucket_d = bucket_q + 9'd1;
                end
              end else begin
                pair_d = pair_q + 6'd1;
              end
            end else begin
              chip_d = chip_q + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      items_left_q <= '0;
      chip_q       <= '0;
      pair_q       <= '0;
      bucket_q     <= '0;
    end else begin
      mode_q       <= mode_d;
      items_left_q <= items_left_d;
      chip_q       <= chip_d;
      pair_q       <= pair_d;
      bucket_q     <= bucket_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfid_queue.sv =====
`default_nettype none

module tfid_queue
  import tfid_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  output logic      full_o,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_job_o
);

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                pop;

  assign full_o      = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_job_o   = mem_q[rd_ptr_q];
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfid_back.sv =====
`default_nettype none

module tfid_back
  import tfid_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  output logic       job_ready_o,
  input  wire job_t  job_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [1:0] chip_o,
  output logic [6:0] channel_o,
  output logic [8:0] bucket_o,
  output logic [11:0] sample_o,
  output logic       bad_channel_o,
  output logic       last_of_item_o,
  output logic       end_of_frame_o
);

  job_t job_q, job_d;
  logic valid_q, valid_d;
  logic phase_q, phase_d;
  logic xfer, done;

  assign out_valid_o    = valid_q;
  assign chip_o         = job_q.chip;
  assign channel_o      = phase_q ? job_q.channel + 7'd1 : job_q.channel;
  assign bucket_o       = job_q.bucket;
  assign sample_o       = phase_q ? job_q.sample1 : job_q.sample0;
  assign bad_channel_o  = channel_o > 7'(CHANNELS - 1);
  assign last_of_item_o = !job_q.two || phase_q;
  assign end_of_frame_o = job_q.eof && last_of_item_o;

  assign xfer        = valid_q && out_ready_i;
  assign done        = xfer && last_of_item_o;
  assign job_ready_o = !valid_q || done;

  always_comb begin
    job_d   = job_q;
    valid_d = valid_q;
    phase_d = phase_q;
    if (job_ready_o) begin
      valid_d = job_valid_i;
      job_d   = job_i;
      phase_d = 1'b0;
    end else if (xfer) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire
